// ===== hw/rtl/arpeggiator_note_sequencer_unit_defines.svh =====
// assertion macros for the arpeggiator note sequencer
`ifndef ARPEGGIATOR_NOTE_SEQUENCER_UNIT_DEFINES_SVH
`define ARPEGGIATOR_NOTE_SEQUENCER_UNIT_DEFINES_SVH

// property checked only outside reset
`define ARPNS_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("arpns check failed");

// property that also covers the reset cycles
`define ARPNS_CHECK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("arpns reset check failed");

`endif

// ===== hw/rtl/arpns_pkg.sv =====
// shared types and constants of the arpeggiator note sequencer
`timescale 1ns / 1ps

package arpns_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int ORD_W      = 12;
  localparam int STEP_W     = 16;
  localparam int PRESS_W    = 8;
  localparam int LEN_W      = 7;
  localparam int OCT_N      = 4;
  localparam int OCT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [NOTE_W-1:0] NOTE_MAX  = 7'd127;
  localparam logic [7:0]        SEMITONES = 8'd12;
  localparam logic [7:0]        ACCENT    = 8'd30;
  localparam logic [PRESS_W-1:0] PRESS_MAX = 8'd255;

  typedef enum logic [2:0] {
    OP_NOTE_ON  = 3'd0,
    OP_NOTE_OFF = 3'd1,
    OP_ALL_OFF  = 3'd2,
    OP_TICK     = 3'd3,
    OP_GATE_END = 3'd4,
    OP_STOP     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PM_UP      = 3'd0,
    PM_DOWN    = 3'd1,
    PM_UPDOWN  = 3'd2,
    PM_DOWNUP  = 3'd3,
    PM_PLAYED  = 3'd4,
    PM_RANDOM  = 3'd5
  } pattern_t;

  typedef enum logic [1:0] {
    VM_NOTE   = 2'd0,
    VM_FIXED  = 2'd1,
    VM_ACCENT = 2'd2
  } vel_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN  = 3'd0,
    CFG_OCTAVES  = 3'd1,
    CFG_LATCH    = 3'd2,
    CFG_VEL_MODE = 3'd3,
    CFG_FIXED_VEL = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ON_SCAN,
    S_ON_ADD,
    S_OFF_SCAN,
    S_OFF_MOVE,
    S_RK_LOAD,
    S_RK_CMP,
    S_LEN,
    S_DIV_START,
    S_DIV_RUN,
    S_MAP,
    S_OCT,
    S_FIND,
    S_EMIT_OFF,
    S_EMIT_ON
  } state_t;

  // handshake between sequencer and modulo unit
  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] rem;
  } div_res_t;

endpackage

// ===== hw/rtl/arpeggiator_note_sequencer_unit.sv =====
// arpeggiator note sequencer top level
// one transaction at a time: in_ready is high only while idle; a step tick runs
//   the rank pass over the note table on a single key comparator, then the modulo unit
// reset: synchronous; clears counters, flags and the sounding note, loads
//   register defaults; the note table is not cleared and needs no sweep
`timescale 1ns / 1ps
`include "arpeggiator_note_sequencer_unit_defines.svh"

module arpeggiator_note_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       op,
  input  logic [arpns_pkg::NOTE_W-1:0]     note,
  input  logic [arpns_pkg::VEL_W-1:0]      velocity,
  input  logic [7:0]                       random_pick,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             is_note_on,
  output logic [arpns_pkg::NOTE_W-1:0]     out_note,
  output logic [arpns_pkg::VEL_W-1:0]      out_velocity,
  output logic                             last,
  input  logic                             cfg_we,
  input  logic [arpns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpns_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = arpns_pkg::IDX_W;
  localparam int CW = arpns_pkg::CNT_W;
  localparam int LW = arpns_pkg::LEN_W;

  arpns_pkg::state_t state, state_next;

  // configuration registers
  logic [2:0] pattern_mode;
  logic [2:0] octave_count;
  logic       latch_enable;
  logic [1:0] velocity_mode;
  logic [6:0] fixed_velocity;

  // note table
  logic [arpns_pkg::NOTE_W-1:0] tab_note  [arpns_pkg::TABLE_DEPTH];
  logic [arpns_pkg::VEL_W-1:0]  tab_vel   [arpns_pkg::TABLE_DEPTH];
  logic [arpns_pkg::ORD_W-1:0]  tab_order [arpns_pkg::TABLE_DEPTH];
  logic [IW-1:0]                rank      [arpns_pkg::TABLE_DEPTH];

  // sequencer state
  logic [CW-1:0]                  held_count;
  logic [arpns_pkg::PRESS_W-1:0]  pressed_count;
  logic [arpns_pkg::ORD_W-1:0]    arrival_counter;
  logic                           latch_stale;
  logic [arpns_pkg::STEP_W-1:0]   step_counter;
  logic                           snd_valid;
  logic [arpns_pkg::NOTE_W-1:0]   snd_note;

  // per-transaction working registers
  logic [arpns_pkg::NOTE_W-1:0] in_note;
  logic [arpns_pkg::VEL_W-1:0]  in_vel;
  logic [7:0]                   in_pick;
  logic [IW-1:0]                idx_j;
  logic [IW-1:0]                idx_m;
  logic [arpns_pkg::ORD_W-1:0]  key_j;
  logic [arpns_pkg::NOTE_W-1:0] note_j;
  logic [IW-1:0]                cnt;
  logic [CW-1:0]                oct_len [arpns_pkg::OCT_N];
  logic [LW-1:0]                base_len;
  logic [LW-1:0]                seq_len;
  logic [LW-1:0]                pos;
  logic [arpns_pkg::OCT_W-1:0]  oct;
  logic                         off_pend;
  logic [arpns_pkg::NOTE_W-1:0] off_note;
  logic                         on_pend;
  logic [arpns_pkg::NOTE_W-1:0] on_note;
  logic [arpns_pkg::VEL_W-1:0]  on_vel;

  // combinational helpers
  logic [IW-1:0]                rd_idx;
  logic [arpns_pkg::NOTE_W-1:0] rd_note;
  logic [arpns_pkg::VEL_W-1:0]  rd_vel;
  logic [arpns_pkg::ORD_W-1:0]  rd_order;
  logic [arpns_pkg::ORD_W-1:0]  key_m;
  logic                         key_less;
  logic [IW-1:0]                cnt_new;
  logic [CW-1:0]                held_m1;
  logic                         in_fire;
  logic                         out_free;
  logic                         stale_press;
  logic                         is_on;
  logic                         is_off;
  logic [arpns_pkg::PRESS_W-1:0] pressed_dec;
  arpns_pkg::pattern_t          pm;
  logic                         by_order;
  logic [2:0]                   octs;
  logic [LW-1:0]                len_sum;
  logic [LW-1:0]                len_total;
  logic [LW-1:0]                map_pos;
  logic [7:0]                   note_shift;
  logic [7:0]                   vel_accent;
  logic [arpns_pkg::VEL_W-1:0]  vel_sel;
  logic                         div_start;
  arpns_pkg::div_res_t          div_res;

  assign in_ready = (state == arpns_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign held_m1  = held_count - CW'(1);
  assign is_on    = (op == arpns_pkg::OP_NOTE_ON) && (velocity != '0);
  assign is_off   = ((op == arpns_pkg::OP_NOTE_ON) && (velocity == '0)) ||
                    (op == arpns_pkg::OP_NOTE_OFF);
  assign stale_press = latch_enable && latch_stale;
  assign pressed_dec = (pressed_count != '0) ? pressed_count - 1'b1 : '0;
  assign div_start = (state == arpns_pkg::S_DIV_START);

  // table read port
  always_comb begin
    case (state)
      arpns_pkg::S_OFF_MOVE: rd_idx = held_m1[IW-1:0];
      arpns_pkg::S_RK_LOAD:  rd_idx = idx_j;
      default:               rd_idx = idx_m;
    endcase
  end
  assign rd_note  = tab_note[rd_idx];
  assign rd_vel   = tab_vel[rd_idx];
  assign rd_order = tab_order[rd_idx];

  // effective register values
  always_comb begin
    if (pattern_mode > arpns_pkg::PM_RANDOM) begin
      pm = arpns_pkg::PM_UP;
    end else begin
      pm = arpns_pkg::pattern_t'(pattern_mode);
    end
    by_order = (pm == arpns_pkg::PM_PLAYED);
    if (octave_count == 3'd0) begin
      octs = 3'd1;
    end else if (octave_count > 3'(arpns_pkg::OCT_N)) begin
      octs = 3'(arpns_pkg::OCT_N);
    end else begin
      octs = octave_count;
    end
  end

  // shared key comparator for the rank pass
  always_comb begin
    key_m    = by_order ? rd_order : arpns_pkg::ORD_W'(rd_note);
    key_less = (key_m < key_j) || ((key_m == key_j) && (idx_m < idx_j));
    cnt_new  = cnt + IW'(key_less);
  end

  // sequence length from the per-octave counts
  always_comb begin
    len_sum = '0;
    for (int o = 0; o < arpns_pkg::OCT_N; o++) begin
      if (3'(o) < octs) begin
        len_sum = len_sum + LW'(oct_len[o]);
      end
    end
    if (((pm == arpns_pkg::PM_UPDOWN) || (pm == arpns_pkg::PM_DOWNUP)) &&
        (len_sum > LW'(1))) begin
      len_total = LW'({len_sum, 1'b0} - 8'd1);
    end else begin
      len_total = len_sum;
    end
  end

  // fold the sequence index back onto the sorted run
  always_comb begin
    case (pm)
      arpns_pkg::PM_DOWN: map_pos = base_len - LW'(1) - div_res.rem;
      arpns_pkg::PM_UPDOWN: begin
        if (div_res.rem < base_len) begin
          map_pos = div_res.rem;
        end else begin
          map_pos = LW'({base_len, 1'b0} - 8'd2 - {1'b0, div_res.rem});
        end
      end
      arpns_pkg::PM_DOWNUP: begin
        if (div_res.rem < base_len) begin
          map_pos = base_len - LW'(1) - div_res.rem;
        end else begin
          map_pos = div_res.rem - base_len + LW'(1);
        end
      end
      default: map_pos = div_res.rem;
    endcase
  end

  // chosen note and its velocity
  always_comb begin
    note_shift = {1'b0, rd_note} + 8'(oct) * arpns_pkg::SEMITONES;
    vel_accent = {1'b0, rd_vel} + arpns_pkg::ACCENT;
    case (velocity_mode)
      arpns_pkg::VM_FIXED: begin
        vel_sel = (fixed_velocity == '0) ? 7'd1 : fixed_velocity;
      end
      arpns_pkg::VM_ACCENT: begin
        if (step_counter[1:0] == 2'd0) begin
          vel_sel = (vel_accent > 8'(arpns_pkg::NOTE_MAX)) ?
                    arpns_pkg::NOTE_MAX : vel_accent[6:0];
        end else begin
          vel_sel = rd_vel;
        end
      end
      default: vel_sel = rd_vel;
    endcase
  end

  arpns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((pm == arpns_pkg::PM_RANDOM) ? arpns_pkg::STEP_W'(in_pick)
                                           : step_counter),
    .divisor  (seq_len),
    .res      (div_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      arpns_pkg::S_IDLE: begin
        if (in_fire) begin
          case (op)
            arpns_pkg::OP_NOTE_ON, arpns_pkg::OP_NOTE_OFF: begin
              if (is_on) begin
                if (stale_press || (held_count == '0)) begin
                  state_next = arpns_pkg::S_ON_ADD;
                end else begin
                  state_next = arpns_pkg::S_ON_SCAN;
                end
              end else if (!latch_enable && (held_count != '0)) begin
                state_next = arpns_pkg::S_OFF_SCAN;
              end
            end
            arpns_pkg::OP_TICK: begin
              if (held_count == '0) begin
                state_next = arpns_pkg::S_EMIT_OFF;
              end else begin
                state_next = arpns_pkg::S_RK_LOAD;
              end
            end
            arpns_pkg::OP_ALL_OFF, arpns_pkg::OP_STOP, arpns_pkg::OP_GATE_END: begin
              state_next = arpns_pkg::S_EMIT_OFF;
            end
            default: state_next = arpns_pkg::S_IDLE;
          endcase
        end
      end
      arpns_pkg::S_ON_SCAN: begin
        if (rd_note == in_note) begin
          state_next = arpns_pkg::S_EMIT_OFF;
        end else if (idx_m == held_m1[IW-1:0]) begin
          state_next = arpns_pkg::S_ON_ADD;
        end
      end
      arpns_pkg::S_ON_ADD: state_next = arpns_pkg::S_EMIT_OFF;
      arpns_pkg::S_OFF_SCAN: begin
        if (rd_note == in_note) begin
          state_next = arpns_pkg::S_OFF_MOVE;
        end else if (idx_m == held_m1[IW-1:0]) begin
          state_next = arpns_pkg::S_IDLE;
        end
      end
      arpns_pkg::S_OFF_MOVE: state_next = arpns_pkg::S_EMIT_OFF;
      arpns_pkg::S_RK_LOAD: state_next = arpns_pkg::S_RK_CMP;
      arpns_pkg::S_RK_CMP: begin
        if (idx_m == held_m1[IW-1:0]) begin
          if (idx_j == held_m1[IW-1:0]) begin
            state_next = arpns_pkg::S_LEN;
          end else begin
            state_next = arpns_pkg::S_RK_LOAD;
          end
        end
      end
      arpns_pkg::S_LEN:       state_next = arpns_pkg::S_DIV_START;
      arpns_pkg::S_DIV_START: state_next = arpns_pkg::S_DIV_RUN;
      arpns_pkg::S_DIV_RUN: begin
        if (div_res.done) begin
          state_next = arpns_pkg::S_MAP;
        end
      end
      arpns_pkg::S_MAP: state_next = arpns_pkg::S_OCT;
      arpns_pkg::S_OCT: begin
        if (pos < LW'(oct_len[oct])) begin
          state_next = arpns_pkg::S_FIND;
        end
      end
      arpns_pkg::S_FIND: begin
        if (rank[idx_m] == pos[IW-1:0]) begin
          state_next = arpns_pkg::S_EMIT_OFF;
        end
      end
      arpns_pkg::S_EMIT_OFF: begin
        if (!off_pend || out_free) begin
          state_next = arpns_pkg::S_EMIT_ON;
        end
      end
      arpns_pkg::S_EMIT_ON: begin
        if (!on_pend || out_free) begin
          state_next = arpns_pkg::S_IDLE;
        end
      end
      default: state_next = arpns_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpns_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode   <= 3'd0;
      octave_count   <= 3'd1;
      latch_enable   <= 1'b0;
      velocity_mode  <= 2'd0;
      fixed_velocity <= 7'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        arpns_pkg::CFG_PATTERN:   pattern_mode   <= cfg_data[2:0];
        arpns_pkg::CFG_OCTAVES:   octave_count   <= cfg_data[2:0];
        arpns_pkg::CFG_LATCH:     latch_enable   <= cfg_data[0];
        arpns_pkg::CFG_VEL_MODE:  velocity_mode  <= cfg_data[1:0];
        arpns_pkg::CFG_FIXED_VEL: fixed_velocity <= cfg_data;
        default: ;
      endcase
    end
  end

  // note table and rank store writes
  always_ff @(posedge clk) begin
    if (state == arpns_pkg::S_ON_ADD && held_count < CW'(arpns_pkg::TABLE_DEPTH)) begin
      tab_note[held_count[IW-1:0]]  <= in_note;
      tab_vel[held_count[IW-1:0]]   <= in_vel;
      tab_order[held_count[IW-1:0]] <= arrival_counter;
    end else if (state == arpns_pkg::S_OFF_MOVE) begin
      tab_note[idx_m]  <= rd_note;
      tab_vel[idx_m]   <= rd_vel;
      tab_order[idx_m] <= rd_order;
    end
    if (state == arpns_pkg::S_RK_CMP && idx_m == held_m1[IW-1:0]) begin
      rank[idx_j] <= cnt_new;
    end
  end

  // control state of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= '0;
      pressed_count   <= '0;
      arrival_counter <= '0;
      latch_stale     <= 1'b0;
      step_counter    <= '0;
      snd_valid       <= 1'b0;
      off_pend        <= 1'b0;
      on_pend         <= 1'b0;
    end else begin
      case (state)
        arpns_pkg::S_IDLE: begin
          if (in_fire) begin
            on_pend  <= 1'b0;
            off_pend <= 1'b0;
            off_note <= snd_note;
            case (op)
              arpns_pkg::OP_NOTE_ON, arpns_pkg::OP_NOTE_OFF: begin
                if (is_on) begin
                  if (pressed_count != arpns_pkg::PRESS_MAX) begin
                    pressed_count <= pressed_count + 1'b1;
                  end
                  if (stale_press) begin
                    off_pend        <= snd_valid;
                    snd_valid       <= 1'b0;
                    held_count      <= '0;
                    arrival_counter <= '0;
                    latch_stale     <= 1'b0;
                    step_counter    <= '0;
                  end
                end else begin
                  pressed_count <= pressed_dec;
                  if (latch_enable && pressed_dec == '0) begin
                    latch_stale <= 1'b1;
                  end
                end
              end
              arpns_pkg::OP_ALL_OFF, arpns_pkg::OP_STOP: begin
                off_pend        <= snd_valid;
                snd_valid       <= 1'b0;
                held_count      <= '0;
                pressed_count   <= '0;
                latch_stale     <= 1'b0;
                arrival_counter <= '0;
                step_counter    <= '0;
              end
              arpns_pkg::OP_TICK, arpns_pkg::OP_GATE_END: begin
                if (op == arpns_pkg::OP_GATE_END || held_count == '0) begin
                  off_pend  <= snd_valid;
                  snd_valid <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        arpns_pkg::S_ON_ADD: begin
          if (held_count < CW'(arpns_pkg::TABLE_DEPTH)) begin
            arrival_counter <= arrival_counter + 1'b1;
            held_count      <= held_count + 1'b1;
            if (held_count == '0) begin
              step_counter <= '0;
              if (snd_valid) begin
                off_pend  <= 1'b1;
                off_note  <= snd_note;
                snd_valid <= 1'b0;
              end
            end
          end
        end
        arpns_pkg::S_OFF_MOVE: begin
          held_count <= held_m1;
          if (held_m1 == '0 && snd_valid) begin
            off_pend  <= 1'b1;
            off_note  <= snd_note;
            snd_valid <= 1'b0;
          end
        end
        arpns_pkg::S_FIND: begin
          if (rank[idx_m] == pos[IW-1:0]) begin
            off_pend     <= snd_valid;
            off_note     <= snd_note;
            on_pend      <= 1'b1;
            on_note      <= note_shift[6:0];
            on_vel       <= vel_sel;
            snd_valid    <= 1'b1;
            snd_note     <= note_shift[6:0];
            step_counter <= step_counter + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    case (state)
      arpns_pkg::S_IDLE: begin
        if (in_fire) begin
          in_note <= note;
          in_pick <= random_pick;
          in_vel  <= velocity;
          idx_m   <= '0;
          idx_j   <= '0;
          for (int o = 0; o < arpns_pkg::OCT_N; o++) begin
            oct_len[o] <= held_count;
          end
        end
      end
      arpns_pkg::S_ON_SCAN, arpns_pkg::S_OFF_SCAN: begin
        if (rd_note != in_note) begin
          idx_m <= idx_m + 1'b1;
        end
      end
      arpns_pkg::S_RK_LOAD: begin
        key_j  <= by_order ? rd_order : arpns_pkg::ORD_W'(rd_note);
        note_j <= rd_note;
        idx_m  <= '0;
        cnt    <= '0;
      end
      arpns_pkg::S_RK_CMP: begin
        cnt   <= cnt_new;
        idx_m <= idx_m + 1'b1;
        if (idx_m == held_m1[IW-1:0]) begin
          idx_j <= idx_j + 1'b1;
          // an entry that overflows an octave cuts that octave at its rank
          for (int o = 1; o < arpns_pkg::OCT_N; o++) begin
            if ({1'b0, note_j} > 8'(arpns_pkg::NOTE_MAX) - 8'(o) * arpns_pkg::SEMITONES &&
                CW'(cnt_new) < oct_len[o]) begin
              oct_len[o] <= CW'(cnt_new);
            end
          end
        end
      end
      arpns_pkg::S_LEN: begin
        base_len <= len_sum;
        seq_len  <= len_total;
      end
      arpns_pkg::S_MAP: begin
        pos <= map_pos;
        oct <= '0;
      end
      arpns_pkg::S_OCT: begin
        idx_m <= '0;
        if (pos >= LW'(oct_len[oct])) begin
          pos <= pos - LW'(oct_len[oct]);
          oct <= oct + 1'b1;
        end
      end
      arpns_pkg::S_FIND: begin
        if (rank[idx_m] != pos[IW-1:0]) begin
          idx_m <= idx_m + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == arpns_pkg::S_EMIT_OFF && off_pend && out_free) begin
      out_valid    <= 1'b1;
      is_note_on   <= 1'b0;
      out_note     <= off_note;
      out_velocity <= '0;
      last         <= !on_pend;
    end else if (state == arpns_pkg::S_EMIT_ON && on_pend && out_free) begin
      out_valid    <= 1'b1;
      is_note_on   <= 1'b1;
      out_note     <= on_note;
      out_velocity <= on_vel;
      last         <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `ARPNS_CHECK_RST(a_reset_clears, rst |=> !out_valid && held_count == '0)
  `ARPNS_CHECK(a_held_bound, held_count <= CW'(arpns_pkg::TABLE_DEPTH))
  `ARPNS_CHECK(a_note_on_last, out_valid && is_note_on |-> last)
  `ARPNS_CHECK(a_off_zero_vel, out_valid && !is_note_on |-> out_velocity == '0)

endmodule

// ===== hw/rtl/arpns_div.sv =====
// restoring modulo unit, one quotient bit per cycle
`timescale 1ns / 1ps

module arpns_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [arpns_pkg::STEP_W-1:0]  dividend,
  input  logic [arpns_pkg::LEN_W-1:0]   divisor,
  output arpns_pkg::div_res_t           res
);

  localparam int BIT_W = $clog2(arpns_pkg::STEP_W);

  logic                         run;
  logic                         done;
  logic [BIT_W-1:0]             bit_cnt;
  logic [arpns_pkg::STEP_W-1:0] shifter;
  logic [arpns_pkg::LEN_W-1:0]  rem;
  logic [arpns_pkg::LEN_W:0]    trial;
  logic [arpns_pkg::LEN_W-1:0]  rem_next;

  // one shift and subtract step
  always_comb begin
    trial = {rem, shifter[arpns_pkg::STEP_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = arpns_pkg::LEN_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[arpns_pkg::LEN_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      bit_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run     <= 1'b1;
        bit_cnt <= '0;
      end else if (run) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_W'(arpns_pkg::STEP_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shifter <= dividend;
      rem     <= '0;
    end else if (run) begin
      shifter <= {shifter[arpns_pkg::STEP_W-2:0], 1'b0};
      rem     <= rem_next;
    end
  end

  assign res = {done, rem};

endmodule
